### src/usvg_pkg.sv
package usvg_pkg;

    localparam int CNT_W = 11;
    localparam int DIV_W = CNT_W + 1;
    localparam int RADIUS_W = 16;
    localparam int PHASE_W = 32;
    localparam int CD_W = 32;
    localparam int Z_W = 33;
    localparam int TEX_W = 16;
    localparam int POS_W = 24;
    localparam int NORM_W = 16;
    localparam int VNUM_W = 21;

    localparam int DEF_MAX_SECTORS = 1024;
    localparam int DEF_MAX_STACKS = 1024;
    localparam logic [CNT_W-1:0] MIN_SECTORS = 11'd3;
    localparam logic [CNT_W-1:0] MIN_STACKS = 11'd2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SECTORS = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    localparam int DIV_STEPS = 33;
    localparam int DIV_STAGES = DIV_STEPS + 1;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_STAGES = CORDIC_STEPS + 2;
    localparam int MUL_STAGES = 4;
    localparam int LATENCY = 1 + DIV_STAGES + CORDIC_STAGES + MUL_STAGES;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [CD_W-1:0] CORDIC_START = 32'sd652032874;
    localparam logic signed [NORM_W+1:0] NORM_ONE = 18'sd16384;

    localparam logic [PHASE_W-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

endpackage

### src/uv_sphere_vertex_generator_unit.sv
// A request passes the input register, divider, CORDIC and multiplier stages.
// Throughput: one request per cycle; the divider steps, CORDIC steps and
// multiplier stages are fully pipelined and the whole pipeline holds when
// the result register is full and not taken.
// Reset clears the valid bits and loads radius 1.0, 36 sectors and 18 stacks.
module uv_sphere_vertex_generator_unit #(
    parameter int MAX_SECTORS = usvg_pkg::DEF_MAX_SECTORS,
    parameter int MAX_STACKS = usvg_pkg::DEF_MAX_STACKS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // stack_index, sector_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                    // tex_s, tex_t, vertex_number
);
    import usvg_pkg::*;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] lo,
                                                    input int hi);
        if (v < lo)
        begin
            return lo;
        end
        else if ({2'b00, v} > 13'(hi))
        begin
            return CNT_W'(hi);
        end
        return v;
    endfunction

    localparam int VN_DEPTH = LATENCY - 1;
    localparam int TEX_DEPTH = CORDIC_STAGES + MUL_STAGES;

    logic [RADIUS_W-1:0] radius_reg;
    logic [CNT_W-1:0] n_reg, n_thr_reg, sc_reg;
    logic [DIV_W-1:0] sc2_reg, sc_thr_reg;
    logic [CNT_W-1:0] n_cl, sc_cl;

    logic en;
    logic vld_reg [0:LATENCY-1];
    logic [CNT_W-1:0] i0_reg, j0_reg;
    logic [CNT_W-1:0] i_in, j_in;
    logic [VNUM_W-1:0] vn_reg [0:VN_DEPTH-1];
    logic [TEX_W-1:0] ts_reg [0:TEX_DEPTH-1];
    logic [TEX_W-1:0] tt_reg [0:TEX_DEPTH-1];
    logic [22:0] vn_next;

    logic [PHASE_W-1:0] ph_u, ph_v, phase_u;
    logic [TEX_W-1:0] tex_s_d, tex_t_d;
    logic signed [CD_W-1:0] cu, su, cv, sv;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;

    assign n_cl = clamp_cnt(cfg_wdata[CNT_W-1:0], MIN_SECTORS, MAX_SECTORS);
    assign sc_cl = clamp_cnt(cfg_wdata[CNT_W-1:0], MIN_STACKS, MAX_STACKS);

    // The stack divider works on twice the count so that its phase covers
    // no more than half a turn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            n_reg <= 11'd36;
            n_thr_reg <= 11'd18;
            sc_reg <= 11'd18;
            sc2_reg <= 12'd36;
            sc_thr_reg <= 12'd18;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:
                begin
                    radius_reg <= cfg_wdata;
                end
                REG_SECTORS:
                begin
                    n_reg <= n_cl;
                    n_thr_reg <= n_cl - (n_cl >> 1);
                end
                REG_STACKS:
                begin
                    sc_reg <= sc_cl;
                    sc2_reg <= {sc_cl, 1'b0};
                    sc_thr_reg <= {sc_cl - (sc_cl >> 1), 1'b0};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign en = !vld_reg[LATENCY-1] || m_tready;
    assign s_tready = en;

    assign i_in = (s_tdata[CNT_W-1:0] > sc_reg) ? sc_reg : s_tdata[CNT_W-1:0];
    assign j_in = (s_tdata[2*CNT_W-1:CNT_W] > n_reg) ? n_reg : s_tdata[2*CNT_W-1:CNT_W];
    assign vn_next = 23'(i0_reg) * 23'({1'b0, n_reg} + 12'd1) + 23'(j0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < LATENCY; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i0_reg <= i_in;
            j0_reg <= j_in;
            vn_reg[0] <= vn_next[VNUM_W-1:0];
            for (int k = 1; k < VN_DEPTH; k++)
            begin
                vn_reg[k] <= vn_reg[k-1];
            end
            ts_reg[0] <= tex_s_d;
            tt_reg[0] <= tex_t_d;
            for (int k = 1; k < TEX_DEPTH; k++)
            begin
                ts_reg[k] <= ts_reg[k-1];
                tt_reg[k] <= tt_reg[k-1];
            end
        end
    end

    usvg_div #(
        .TEX_TAP(16)
    ) u_div_stack (
        .clk(clk),
        .en(en),
        .dividend(i0_reg),
        .divisor(sc2_reg),
        .thresh(sc_thr_reg),
        .phase(ph_u),
        .tex(tex_t_d)
    );

    usvg_div #(
        .TEX_TAP(15)
    ) u_div_sector (
        .clk(clk),
        .en(en),
        .dividend(j0_reg),
        .divisor({1'b0, n_reg}),
        .thresh({1'b0, n_thr_reg}),
        .phase(ph_v),
        .tex(tex_s_d)
    );

    assign phase_u = QUARTER_TURN - ph_u;

    usvg_cordic u_cordic_u (
        .clk(clk),
        .en(en),
        .phase(phase_u),
        .cos_val(cu),
        .sin_val(su)
    );

    usvg_cordic u_cordic_v (
        .clk(clk),
        .en(en),
        .phase(ph_v),
        .cos_val(cv),
        .sin_val(sv)
    );

    usvg_mul u_mul (
        .clk(clk),
        .en(en),
        .radius(radius_reg),
        .cu(cu),
        .su(su),
        .cv(cv),
        .sv(sv),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .norm_x(norm_x),
        .norm_y(norm_y),
        .norm_z(norm_z)
    );

    assign m_tvalid = vld_reg[LATENCY-1];
    assign m_tdata = {3'b000, vn_reg[VN_DEPTH-1], tt_reg[TEX_DEPTH-1], ts_reg[TEX_DEPTH-1],
                      norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};

`ifndef NO_ASSERTIONS
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg >= MIN_SECTORS && sc_reg >= MIN_STACKS && sc2_reg == {sc_reg, 1'b0})
        else $error("clamped counts out of range");
    a_tex: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[135:120] <= 16'd32768 && m_tdata[151:136] <= 16'd32768))
        else $error("texture coordinate above one");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[87:72]) <= 16'sd16384
                      && $signed(m_tdata[87:72]) >= -16'sd16384
                      && $signed(m_tdata[119:104]) <= 16'sd16384
                      && $signed(m_tdata[119:104]) >= -16'sd16384))
        else $error("normal component beyond unit");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg[0]))
        else $error("pipeline moved while result was stalled");
`endif

endmodule

### src/usvg_div.sv
module usvg_div #(
    parameter int TEX_TAP = 15
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [usvg_pkg::CNT_W-1:0] dividend,
    input  logic [usvg_pkg::DIV_W-1:0] divisor,
    input  logic [usvg_pkg::DIV_W-1:0] thresh,
    output logic [usvg_pkg::PHASE_W-1:0] phase,
    output logic [usvg_pkg::TEX_W-1:0] tex
);
    import usvg_pkg::*;

    localparam int QW = DIV_STEPS;

    logic [DIV_W-1:0] rem_reg [0:DIV_STEPS-1];
    logic [QW-1:0] quo_reg [0:DIV_STEPS-1];
    logic [TEX_W-1:0] tex_reg [TEX_TAP+1:DIV_STEPS];
    logic [PHASE_W-1:0] ph_reg;

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [DIV_W:0] t;
            logic [QW-1:0] q_in;
            logic b;
            if (k == 0)
            begin : g_first
                assign t = {2'b00, dividend};
                assign q_in = '0;
            end
            else
            begin : g_next
                assign t = {rem_reg[k-1], 1'b0};
                assign q_in = quo_reg[k-1];
            end
            assign b = (t >= {1'b0, divisor});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= b ? DIV_W'(t - {1'b0, divisor}) : t[DIV_W-1:0];
                    quo_reg[k] <= {q_in[QW-2:0], b};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tex_reg[TEX_TAP+1] <= quo_reg[TEX_TAP][TEX_W-1:0]
                + TEX_W'(rem_reg[TEX_TAP] >= thresh);
            for (int i = TEX_TAP + 2; i <= DIV_STEPS; i++)
            begin
                tex_reg[i] <= tex_reg[i-1];
            end
            ph_reg <= quo_reg[DIV_STEPS-1][PHASE_W-1:0]
                + PHASE_W'(rem_reg[DIV_STEPS-1] >= thresh);
        end
    end

    assign phase = ph_reg;
    assign tex = tex_reg[DIV_STEPS];

endmodule

### src/usvg_cordic.sv
module usvg_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic [usvg_pkg::PHASE_W-1:0]        phase,
    output logic signed [usvg_pkg::CD_W-1:0]    cos_val,
    output logic signed [usvg_pkg::CD_W-1:0]    sin_val
);
    import usvg_pkg::*;

    logic signed [Z_W-1:0] z_pre_reg;
    logic f_pre_reg;
    logic signed [CD_W-1:0] x_reg [0:CORDIC_STEPS-1];
    logic signed [CD_W-1:0] y_reg [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0] z_reg [0:CORDIC_STEPS-2];
    logic f_reg [0:CORDIC_STEPS-1];
    logic signed [CD_W-1:0] cos_reg;
    logic signed [CD_W-1:0] sin_reg;

    logic flip;
    logic [PHASE_W-1:0] folded;

    // A phase in the left half plane is turned by half a turn and the
    // results are negated at the end.
    assign flip = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    assign folded = {phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_pre_reg <= {folded[PHASE_W-1], folded};
            f_pre_reg <= flip;
        end
    end

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_step
            logic signed [CD_W-1:0] xi;
            logic signed [CD_W-1:0] yi;
            logic signed [Z_W-1:0] zi;
            logic fi;
            logic signed [Z_W-1:0] ang;
            if (k == 0)
            begin : g_first
                assign xi = CORDIC_START;
                assign yi = '0;
                assign zi = z_pre_reg;
                assign fi = f_pre_reg;
            end
            else
            begin : g_next
                assign xi = x_reg[k-1];
                assign yi = y_reg[k-1];
                assign zi = z_reg[k-1];
                assign fi = f_reg[k-1];
            end
            assign ang = $signed({1'b0, ATAN_TURNS[k]});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!zi[Z_W-1])
                    begin
                        x_reg[k] <= xi - (yi >>> k);
                        y_reg[k] <= yi + (xi >>> k);
                    end
                    else
                    begin
                        x_reg[k] <= xi + (yi >>> k);
                        y_reg[k] <= yi - (xi >>> k);
                    end
                    f_reg[k] <= fi;
                end
            end
            if (k < CORDIC_STEPS - 1)
            begin : g_z
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        z_reg[k] <= zi[Z_W-1] ? zi + ang : zi - ang;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= f_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
            sin_reg <= f_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

### src/usvg_mul.sv
module usvg_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [usvg_pkg::RADIUS_W-1:0]        radius,
    input  logic signed [usvg_pkg::CD_W-1:0]     cu,
    input  logic signed [usvg_pkg::CD_W-1:0]     su,
    input  logic signed [usvg_pkg::CD_W-1:0]     cv,
    input  logic signed [usvg_pkg::CD_W-1:0]     sv,
    output logic signed [usvg_pkg::POS_W-1:0]    pos_x,
    output logic signed [usvg_pkg::POS_W-1:0]    pos_y,
    output logic signed [usvg_pkg::POS_W-1:0]    pos_z,
    output logic signed [usvg_pkg::NORM_W-1:0]   norm_x,
    output logic signed [usvg_pkg::NORM_W-1:0]   norm_y,
    output logic signed [usvg_pkg::NORM_W-1:0]   norm_z
);
    import usvg_pkg::*;

    function automatic logic signed [NORM_W-1:0] clamp_norm(input logic signed [NORM_W+1:0] v);
        if (v > NORM_ONE)
        begin
            return NORM_ONE[NORM_W-1:0];
        end
        else if (v < -NORM_ONE)
        begin
            return -NORM_ONE[NORM_W-1:0];
        end
        return v[NORM_W-1:0];
    endfunction

    logic signed [63:0] pnx_reg, pny_reg;
    logic signed [48:0] prc_reg, ppz_reg;
    logic signed [NORM_W-1:0] nz1_reg;
    logic signed [CD_W-1:0] cv1_reg, sv1_reg;

    logic signed [NORM_W-1:0] nx2_reg, ny2_reg, nz2_reg;
    logic signed [32:0] rc2_reg;
    logic signed [POS_W-1:0] pz2_reg;
    logic signed [CD_W-1:0] cv2_reg, sv2_reg;

    logic signed [64:0] ppx3_reg, ppy3_reg;
    logic signed [NORM_W-1:0] nx3_reg, ny3_reg, nz3_reg;
    logic signed [POS_W-1:0] pz3_reg;

    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;

    logic signed [CD_W-1:0] snz;
    logic signed [63:0] snx, sny;
    logic signed [48:0] src, spz;
    logic signed [64:0] spx, spy;

    always_comb
    begin
        snz = su + 32'sd32768;
        snx = pnx_reg + (64'sd1 <<< 45);
        sny = pny_reg + (64'sd1 <<< 45);
        src = prc_reg + 49'sd32768;
        spz = ppz_reg + (49'sd1 <<< 23);
        spx = ppx3_reg + (65'sd1 <<< 37);
        spy = ppy3_reg + (65'sd1 <<< 37);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pnx_reg <= cu * cv;
            pny_reg <= cu * sv;
            prc_reg <= $signed({1'b0, radius}) * cu;
            ppz_reg <= $signed({1'b0, radius}) * su;
            nz1_reg <= clamp_norm({{2{snz[CD_W-1]}}, snz[CD_W-1:16]});
            cv1_reg <= cv;
            sv1_reg <= sv;

            nx2_reg <= clamp_norm(snx[63:46]);
            ny2_reg <= clamp_norm(sny[63:46]);
            rc2_reg <= src[48:16];
            pz2_reg <= spz[47:24];
            nz2_reg <= nz1_reg;
            cv2_reg <= cv1_reg;
            sv2_reg <= sv1_reg;

            ppx3_reg <= rc2_reg * cv2_reg;
            ppy3_reg <= rc2_reg * sv2_reg;
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            nz3_reg <= nz2_reg;
            pz3_reg <= pz2_reg;

            px_reg <= spx[61:38];
            py_reg <= spy[61:38];
            pz_reg <= pz3_reg;
            nx_reg <= nx3_reg;
            ny_reg <= ny3_reg;
            nz_reg <= nz3_reg;
        end
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_z = pz_reg;
    assign norm_x = nx_reg;
    assign norm_y = ny_reg;
    assign norm_z = nz_reg;

endmodule
